[src/ils_pkg.sv]
package ils_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned SqrtSteps = 48;
  localparam int unsigned DivSteps  = 32;

  typedef struct packed {
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic signed [23:0] tz;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic signed [19:0] vz;
  } tgt_t;

  typedef struct packed {
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    tgt_t               tgt;
    logic [18:0]        sp;
  } in_t;

  typedef struct packed {
    logic signed [40:0] a;
    logic signed [47:0] b;
    logic [49:0]        c;
    tgt_t               tgt;
  } coef_t;

  typedef struct packed {
    tgt_t               tgt;
    logic               lin_have;
    logic [49:0]        lin_num;
    logic [47:0]        lin_den;
    logic               a_pos;
    logic               quad;
    logic signed [47:0] b;
    logic [40:0]        absa;
  } sqrt_meta_t;

  typedef struct packed {
    tgt_t tgt;
    logic have;
  } div_meta_t;

  typedef struct packed {
    logic signed [23:0] lead_x;
    logic signed [23:0] lead_y;
    logic signed [23:0] lead_z;
    logic [31:0]        intercept_time;
    logic               found;
  } out_t;

endpackage

[src/intercept_lead_solver_top.sv]
// Projectile lead solver. Takes one item per cycle while s_axis_tready is high and
// returns one result per item, in order. The back end holds the 48-step square-root
// pipeline and the 32-step quotient pipeline; a four-entry queue between the
// coefficient front end and the back end lets either side stall alone,
// and the back end holds while the output item waits to be taken.
module intercept_lead_solver_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // shooter_x, shooter_y, shooter_z, target_x, target_y, target_z,
  // target_vel_x, target_vel_y, target_vel_z, projectile_speed, 1 pad bit
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lead_x, lead_y, lead_z, intercept_time
  output logic [103:0] m_axis_tdata,
  // found
  output logic [0:0]   m_axis_tuser
);
  import ils_pkg::*;

  in_t   in_d;
  coef_t push_data, head;
  logic  push, full, pop, empty;
  out_t  res;

  assign in_d.sx     = s_axis_tdata[23:0];
  assign in_d.sy     = s_axis_tdata[47:24];
  assign in_d.sz     = s_axis_tdata[71:48];
  assign in_d.tgt.tx = s_axis_tdata[95:72];
  assign in_d.tgt.ty = s_axis_tdata[119:96];
  assign in_d.tgt.tz = s_axis_tdata[143:120];
  assign in_d.tgt.vx = s_axis_tdata[163:144];
  assign in_d.tgt.vy = s_axis_tdata[183:164];
  assign in_d.tgt.vz = s_axis_tdata[203:184];
  assign in_d.sp     = s_axis_tdata[222:204];

  ils_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (in_d),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  ils_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  ils_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (res)
  );

  assign m_axis_tdata = {res.intercept_time, res.lead_z, res.lead_y, res.lead_x};
  assign m_axis_tuser = res.found;

endmodule

[src/ils_front.sv]
module ils_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ils_pkg::in_t  in_data_i,
  output logic          push_o,
  output ils_pkg::coef_t push_data_o,
  input  logic          full_i
);
  import ils_pkg::*;

  logic v0_q, v1_q, v2_q, en;

  logic signed [24:0] dx_q, dy_q, dz_q;
  tgt_t               tgt0_q, tgt1_q;
  logic [18:0]        sp0_q;

  logic signed [49:0] ddx_q, ddy_q, ddz_q;
  logic signed [44:0] dvx_q, dvy_q, dvz_q;
  logic signed [39:0] vvx_q, vvy_q, vvz_q;
  logic [37:0]        ss_q;

  logic signed [51:0] csum;
  logic signed [47:0] bsum;
  logic signed [40:0] asum;
  coef_t              coef_q;

  assign en          = !(v2_q && full_i);
  assign in_ready_o  = en;
  assign push_o      = v2_q && !full_i;
  assign push_data_o = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  assign csum = 52'(ddx_q) + 52'(ddy_q) + 52'(ddz_q);
  assign bsum = 48'(dvx_q) + 48'(dvy_q) + 48'(dvz_q);
  assign asum = 41'(vvx_q) + 41'(vvy_q) + 41'(vvz_q) - $signed({3'b000, ss_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q   <= 25'(in_data_i.tgt.tx) - 25'(in_data_i.sx);
      dy_q   <= 25'(in_data_i.tgt.ty) - 25'(in_data_i.sy);
      dz_q   <= 25'(in_data_i.tgt.tz) - 25'(in_data_i.sz);
      tgt0_q <= in_data_i.tgt;
      sp0_q  <= in_data_i.sp;

      ddx_q  <= dx_q * dx_q;
      ddy_q  <= dy_q * dy_q;
      ddz_q  <= dz_q * dz_q;
      dvx_q  <= dx_q * tgt0_q.vx;
      dvy_q  <= dy_q * tgt0_q.vy;
      dvz_q  <= dz_q * tgt0_q.vz;
      vvx_q  <= tgt0_q.vx * tgt0_q.vx;
      vvy_q  <= tgt0_q.vy * tgt0_q.vy;
      vvz_q  <= tgt0_q.vz * tgt0_q.vz;
      ss_q   <= sp0_q * sp0_q;
      tgt1_q <= tgt0_q;

      coef_q.a   <= asum;
      coef_q.b   <= bsum <<< 1;
      coef_q.c   <= csum[49:0];
      coef_q.tgt <= tgt1_q;
    end
  end

endmodule

[src/ils_fifo.sv]
module ils_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ils_pkg::coef_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ils_pkg::coef_t head_o
);
  import ils_pkg::*;

  coef_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;

  assign full_o  = cnt_q == (FifoPtrW + 1)'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

[src/ils_sqrt.sv]
module ils_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  logic [95:0]        in_rad_i,
  input  ils_pkg::sqrt_meta_t in_meta_i,
  output logic               out_valid_o,
  output logic [47:0]        out_root_o,
  output ils_pkg::sqrt_meta_t out_meta_o
);
  import ils_pkg::*;

  logic       vld_q  [SqrtSteps];
  logic [95:0] rad_q [SqrtSteps];
  logic [49:0] rem_q [SqrtSteps];
  logic [47:0] root_q[SqrtSteps];
  sqrt_meta_t  meta_q[SqrtSteps];

  logic [95:0] rad_d [SqrtSteps];
  logic [49:0] rem_d [SqrtSteps];
  logic [47:0] root_d[SqrtSteps];

  always_comb begin
    logic [95:0] rad_s;
    logic [49:0] rem_s;
    logic [47:0] root_s;
    logic [51:0] rem2, trial;
    for (int k = 0; k < SqrtSteps; k++) begin
      if (k == 0) begin
        rad_s  = in_rad_i;
        rem_s  = '0;
        root_s = '0;
      end else begin
        rad_s  = rad_q[k-1];
        rem_s  = rem_q[k-1];
        root_s = root_q[k-1];
      end
      rem2  = {rem_s, rad_s[95:94]};
      trial = {2'b00, root_s, 2'b01};
      rad_d[k] = rad_s << 2;
      if (rem2 >= trial) begin
        rem_d[k]  = 50'(rem2 - trial);
        root_d[k] = {root_s[46:0], 1'b1};
      end else begin
        rem_d[k]  = rem2[49:0];
        root_d[k] = {root_s[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqrtSteps; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < SqrtSteps; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= in_meta_i;
      for (int k = 1; k < SqrtSteps; k++) meta_q[k] <= meta_q[k-1];
      for (int k = 0; k < SqrtSteps; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign out_valid_o = vld_q[SqrtSteps-1];
  assign out_root_o  = root_q[SqrtSteps-1];
  assign out_meta_o  = meta_q[SqrtSteps-1];

endmodule

[src/ils_div.sv]
module ils_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  logic [49:0]       in_num_i,
  input  logic [47:0]       in_den_i,
  input  ils_pkg::div_meta_t in_meta_i,
  output logic              out_valid_o,
  output logic [31:0]       out_quo_o,
  output logic              out_sat_o,
  output ils_pkg::div_meta_t out_meta_o
);
  import ils_pkg::*;

  logic        vld_q [DivSteps];
  logic [47:0] rem_q [DivSteps];
  logic [31:0] lq_q  [DivSteps];
  logic [47:0] den_q [DivSteps];
  logic        sat_q [DivSteps];
  div_meta_t   meta_q[DivSteps];

  logic [47:0] rem_d [DivSteps];
  logic [31:0] lq_d  [DivSteps];

  always_comb begin
    logic [47:0] rem_s, den_s;
    logic [31:0] lq_s;
    logic [48:0] r2;
    for (int k = 0; k < DivSteps; k++) begin
      if (k == 0) begin
        rem_s = 48'(in_num_i >> 16);
        lq_s  = {in_num_i[15:0], 16'h0000};
        den_s = in_den_i;
      end else begin
        rem_s = rem_q[k-1];
        lq_s  = lq_q[k-1];
        den_s = den_q[k-1];
      end
      r2 = {rem_s, lq_s[31]};
      if (r2 >= {1'b0, den_s}) begin
        rem_d[k] = 48'(r2 - {1'b0, den_s});
        lq_d[k]  = {lq_s[30:0], 1'b1};
      end else begin
        rem_d[k] = r2[47:0];
        lq_d[k]  = {lq_s[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivSteps; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < DivSteps; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= in_meta_i;
      den_q[0]  <= in_den_i;
      sat_q[0]  <= {14'h0000, in_num_i} >= {in_den_i, 16'h0000};
      for (int k = 1; k < DivSteps; k++) begin
        meta_q[k] <= meta_q[k-1];
        den_q[k]  <= den_q[k-1];
        sat_q[k]  <= sat_q[k-1];
      end
      for (int k = 0; k < DivSteps; k++) begin
        rem_q[k] <= rem_d[k];
        lq_q[k]  <= lq_d[k];
      end
    end
  end

  assign out_valid_o = vld_q[DivSteps-1];
  assign out_quo_o   = lq_q[DivSteps-1];
  assign out_sat_o   = sat_q[DivSteps-1];
  assign out_meta_o  = meta_q[DivSteps-1];

endmodule

[src/ils_back.sv]
module ils_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  ils_pkg::coef_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ils_pkg::out_t  out_data_o
);
  import ils_pkg::*;

  typedef struct packed {
    tgt_t               tgt;
    logic signed [47:0] b;
    logic [40:0]        absa;
    logic [47:0]        absb;
    logic [49:0]        uc;
    logic               a_pos;
    logic               a_nz;
    logic               b_neg;
    logic               lin;
    logic               lin_have;
  } bk_t;

  logic en;
  logic b0v_q, b1v_q, b2v_q, b3v_q, b4v_q, nv_q, l0v_q, ov_q;

  coef_t b0_q;
  bk_t   b1_q, b2_q, b3_q;
  bk_t   b1_d, b2_d;

  // coefficient products, split into partial products
  logic [47:0] pbhh_q, pbhl_q, pbll_q;
  logic [41:0] pahch_q, pahcl_q;
  logic [48:0] palch_q, palcl_q;
  logic [95:0] bb_q, fac_q;

  logic [49:0] ref_v;
  logic [50:0] ref_up;
  logic        lin, lin_ok;
  logic [95:0] bb_d, fac_d;
  logic        ge;

  logic [95:0] disc_q;
  sqrt_meta_t  sm_q;

  logic        sq_v;
  logic [47:0] sq_root;
  sqrt_meta_t  sq_meta;

  logic signed [49:0] nb, sq_s, n0, n1, nsel;
  logic               p0, p1, quad_have;
  logic [49:0]        absn;
  logic [49:0]        num_q;
  logic [47:0]        den_q;
  div_meta_t          dm_q;

  logic        dv_v;
  logic [31:0] dv_quo;
  logic        dv_sat;
  div_meta_t   dv_meta;

  logic [31:0]        t_d, t_q;
  logic               fnd_q;
  tgt_t               tgt_l_q;
  logic signed [52:0] px_q, py_q, pz_q;
  out_t               out_q;

  function automatic logic signed [23:0] sat24(logic signed [37:0] r);
    if (r > 38'sd8388607) return 24'sh7FFFFF;
    if (r < -38'sd8388608) return 24'sh800000;
    return r[23:0];
  endfunction

  function automatic logic signed [23:0] lead_axis(logic signed [23:0] tgt,
                                                   logic signed [52:0] p);
    logic signed [36:0] sh;
    sh = p[52:16];
    return sat24(38'(tgt) + 38'(sh));
  endfunction

  assign en          = !ov_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0v_q <= 1'b0;
      b1v_q <= 1'b0;
      b2v_q <= 1'b0;
      b3v_q <= 1'b0;
      b4v_q <= 1'b0;
      nv_q  <= 1'b0;
      l0v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else if (en) begin
      b0v_q <= !empty_i;
      b1v_q <= b0v_q;
      b2v_q <= b1v_q;
      b3v_q <= b2v_q;
      b4v_q <= b3v_q;
      nv_q  <= sq_v;
      l0v_q <= dv_v;
      ov_q  <= l0v_q;
    end
  end

  // B0: magnitudes
  always_comb begin
    b1_d          = '0;
    b1_d.tgt      = b0_q.tgt;
    b1_d.b        = b0_q.b;
    b1_d.absa     = b0_q.a[40] ? 41'(-b0_q.a) : 41'(b0_q.a);
    b1_d.absb     = b0_q.b[47] ? 48'(-b0_q.b) : 48'(b0_q.b);
    b1_d.uc       = b0_q.c;
    b1_d.a_pos    = !b0_q.a[40] && (b0_q.a != '0);
    b1_d.a_nz     = b0_q.a != '0;
    b1_d.b_neg    = b0_q.b[47];
  end

  // B1: degenerate test against max(|a|,|b|,|c|) / 2^20
  always_comb begin
    ref_v = 50'(b1_q.absa);
    if (50'(b1_q.absb) > ref_v) ref_v = 50'(b1_q.absb);
    if (b1_q.uc > ref_v) ref_v = b1_q.uc;
    ref_up = {1'b0, ref_v} + 51'(20'hFFFFF);
    lin    = 51'(b1_q.absa) < (ref_up >> 20);
    lin_ok = (50'(b1_q.absb) > (ref_v >> 20)) && b1_q.b_neg && (b1_q.uc != '0);
    b2_d          = b1_q;
    b2_d.lin      = lin;
    b2_d.lin_have = lin && lin_ok;
  end

  // B2: sum partial products
  assign bb_d = (96'(pbhh_q) << 48) + (96'(pbhl_q) << 25) + 96'(pbll_q);
  assign fac_d = ((96'(pahch_q) << 49) + (96'(pahcl_q) << 24) + (96'(palch_q) << 25)
                 + 96'(palcl_q)) << 2;

  // B3: discriminant
  assign ge = bb_q >= fac_q;

  // after sqrt: root selection
  always_comb begin
    nb   = -(50'(sq_meta.b));
    sq_s = $signed({2'b00, sq_root});
    n0   = nb - sq_s;
    n1   = nb + sq_s;
    p0   = sq_meta.a_pos ? (!n0[49] && n0 != '0) : n0[49];
    p1   = sq_meta.a_pos ? (!n1[49] && n1 != '0) : n1[49];
    if (sq_meta.a_pos) nsel = p0 ? n0 : n1;
    else               nsel = p1 ? n1 : n0;
    quad_have = sq_meta.quad && (p0 || p1);
    absn      = nsel[49] ? 50'(-nsel) : 50'(nsel);
  end

  assign t_d = dv_sat ? 32'hFFFF_FFFF : dv_quo;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pop_o) b0_q <= head_i;
      else       b0_q <= b0_q;

      b1_q <= b1_d;

      b2_q    <= b2_d;
      pbhh_q  <= b1_q.absb[47:24] * b1_q.absb[47:24];
      pbhl_q  <= b1_q.absb[47:24] * b1_q.absb[23:0];
      pbll_q  <= b1_q.absb[23:0] * b1_q.absb[23:0];
      pahch_q <= b1_q.absa[40:24] * b1_q.uc[49:25];
      pahcl_q <= b1_q.absa[40:24] * b1_q.uc[24:0];
      palch_q <= b1_q.absa[23:0] * b1_q.uc[49:25];
      palcl_q <= b1_q.absa[23:0] * b1_q.uc[24:0];

      b3_q  <= b2_q;
      bb_q  <= bb_d;
      fac_q <= fac_d;

      disc_q        <= b3_q.a_pos ? (bb_q - fac_q) : (bb_q + fac_q);
      sm_q.tgt      <= b3_q.tgt;
      sm_q.lin_have <= b3_q.lin_have;
      sm_q.lin_num  <= b3_q.uc;
      sm_q.lin_den  <= b3_q.absb;
      sm_q.a_pos    <= b3_q.a_pos;
      sm_q.quad     <= !b3_q.lin && b3_q.a_nz && (!b3_q.a_pos || ge);
      sm_q.b        <= b3_q.b;
      sm_q.absa     <= b3_q.absa;

      dm_q.tgt  <= sq_meta.tgt;
      dm_q.have <= sq_meta.lin_have || quad_have;
      if (sq_meta.lin_have) begin
        num_q <= sq_meta.lin_num;
        den_q <= sq_meta.lin_den;
      end else begin
        num_q <= absn;
        den_q <= {6'b000000, sq_meta.absa, 1'b0};
      end

      t_q     <= t_d;
      fnd_q   <= dv_meta.have && (t_d != '0);
      tgt_l_q <= dv_meta.tgt;
      px_q    <= dv_meta.tgt.vx * $signed({1'b0, t_d});
      py_q    <= dv_meta.tgt.vy * $signed({1'b0, t_d});
      pz_q    <= dv_meta.tgt.vz * $signed({1'b0, t_d});

      if (fnd_q) begin
        out_q.lead_x         <= lead_axis(tgt_l_q.tx, px_q);
        out_q.lead_y         <= lead_axis(tgt_l_q.ty, py_q);
        out_q.lead_z         <= lead_axis(tgt_l_q.tz, pz_q);
        out_q.intercept_time <= t_q;
        out_q.found          <= 1'b1;
      end else begin
        out_q.lead_x         <= tgt_l_q.tx;
        out_q.lead_y         <= tgt_l_q.ty;
        out_q.lead_z         <= tgt_l_q.tz;
        out_q.intercept_time <= '0;
        out_q.found          <= 1'b0;
      end
    end
  end

  ils_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (b4v_q),
    .in_rad_i   (disc_q),
    .in_meta_i  (sm_q),
    .out_valid_o(sq_v),
    .out_root_o (sq_root),
    .out_meta_o (sq_meta)
  );

  ils_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (nv_q),
    .in_num_i   (num_q),
    .in_den_i   (den_q),
    .in_meta_i  (dm_q),
    .out_valid_o(dv_v),
    .out_quo_o  (dv_quo),
    .out_sat_o  (dv_sat),
    .out_meta_o (dv_meta)
  );

endmodule
